>>> design/rgta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgta_pkg;

    // Slot counts of the two stored tiers.
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int HOURS_PER_HALF_DAY = 12;

    // Index widths; the shared sweep address covers the wider of the two.
    localparam int MIN_IDX_W = $clog2(MINUTES_PER_HOUR);
    localparam int HR_IDX_W  = $clog2(HOURS_PER_HALF_DAY);
    localparam int ADDR_W    = (MIN_IDX_W > HR_IDX_W) ? MIN_IDX_W : HR_IDX_W;

    // Field widths in 0.001 mm units.
    localparam int RES_W   = 16;
    localparam int CNT_W   = 12;
    localparam int MIN_W   = 28;
    localparam int HOUR_W  = 34;
    localparam int HALF_W  = 38;
    localparam int DAY_W   = 39;
    localparam int TOTAL_W = 48;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RES_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_MODE = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MSUM,
        ST_HSUM,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

>>> design/rgta_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rgta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rain_gauge_tiered_accumulator.sv
// From acceptance of a minute transaction to acceptance of its result, the block sweeps the minute
// slots below the minute index, and in tiered mode also the hour slots below the hour index.
// Throughput: one transaction at a time, set by the sweeps over the minute and hour slot RAMs,
// which read one slot per cycle through their single read ports.
// Reset (synchronous, active low) clears indices, half-day slots, total and configuration;
`timescale 1ns / 1ps
`default_nettype none

// The slot RAMs need no clearing, as only slots already written this pass are ever read.
module rain_gauge_tiered_accumulator
    import rgta_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // minute tick channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [CNT_W-1:0]      i_impulse_count,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [MIN_W-1:0]      o_minute_level,
    output logic      [HOUR_W-1:0]     o_hour_level,
    output logic      [HALF_W-1:0]     o_half_day_level,
    output logic      [DAY_W-1:0]      o_day_level,
    output logic      [TOTAL_W-1:0]    o_running_total
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [RES_W-1:0]     r_res, n_res;
    logic                 r_cmode, n_cmode;
    logic [MIN_IDX_W-1:0] r_min_idx, n_min_idx;
    logic [HR_IDX_W-1:0]  r_hr_idx, n_hr_idx;
    logic                 r_hd_idx, n_hd_idx;
    logic [HALF_W-1:0]    r_half_slot [2];
    logic [HALF_W-1:0]    n_half_slot [2];
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic                 r_mwrap, n_mwrap;
    logic                 r_o_valid, n_o_valid;

    // ------------------------------------------------------------------
    // Working values and result payload
    // ------------------------------------------------------------------
    logic [MIN_W-1:0]     r_minute, n_minute;
    logic [HOUR_W-1:0]    r_hour, n_hour;
    logic [HALF_W-1:0]    r_half, n_half;
    logic [DAY_W-1:0]     r_day, n_day;
    logic [HALF_W-1:0]    r_acc, n_acc;
    logic [MIN_W-1:0]     r_out_minute, n_out_minute;
    logic [HOUR_W-1:0]    r_out_hour, n_out_hour;
    logic [HALF_W-1:0]    r_out_half, n_out_half;
    logic [DAY_W-1:0]     r_out_day, n_out_day;
    logic [TOTAL_W-1:0]   r_out_total, n_out_total;

    // RAM ports
    logic                 min_we;
    logic [MIN_W-1:0]     min_rdata;
    logic                 hr_we;
    logic [HOUR_W-1:0]    hr_rdata;

    // Sweep control shared by both tiers
    logic [ADDR_W-1:0]    sweep_limit;
    logic                 sweep_issue;
    logic                 sweep_done;
    logic                 out_free;
    logic                 in_accept;
    logic                 min_wrap;

    // Minute slots hold one minute level each; hour slots one hour level each.
    // A slot is written only when its sweep finishes, and every sweep reads
    // strictly below the current index, so a read never meets a pending write.
    rgta_ram #(
        .WIDTH (MIN_W),
        .DEPTH (MINUTES_PER_HOUR)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (r_min_idx),
        .i_wdata (r_minute),
        .i_raddr (r_addr[MIN_IDX_W-1:0]),
        .o_rdata (min_rdata)
    );

    rgta_ram #(
        .WIDTH (HOUR_W),
        .DEPTH (HOURS_PER_HALF_DAY)
    ) u_hr_ram (
        .i_clk   (i_clk),
        .i_we    (hr_we),
        .i_waddr (r_hr_idx),
        .i_wdata (r_hour),
        .i_raddr (r_addr[HR_IDX_W-1:0]),
        .o_rdata (hr_rdata)
    );

    assign in_accept = i_valid && (r_state == ST_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign min_wrap  = (r_min_idx >= MIN_IDX_W'(MINUTES_PER_HOUR - 1));

    // The sweep reads slots 0 .. index-1 one per cycle; the data of each read
    // is registered in the RAM and added into the accumulator in the cycle after the read; the accumulator already
    // holds the level of the current slot.
    assign sweep_limit = (r_state == ST_HSUM) ? ADDR_W'(r_hr_idx) : ADDR_W'(r_min_idx);
    assign sweep_issue = (r_addr < sweep_limit);
    assign sweep_done  = !sweep_issue && !r_pend;

    assign min_we = (r_state == ST_MSUM) && sweep_done;
    assign hr_we  = (r_state == ST_HSUM) && sweep_done;

    // ------------------------------------------------------------------
    // Next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_cmode      = r_cmode;
        n_min_idx    = r_min_idx;
        n_hr_idx     = r_hr_idx;
        n_hd_idx     = r_hd_idx;
        n_half_slot  = r_half_slot;
        n_total      = r_total;
        n_addr       = r_addr;
        n_pend       = r_pend;
        n_mwrap      = r_mwrap;
        n_o_valid    = r_o_valid && i_stall;
        n_minute     = r_minute;
        n_hour       = r_hour;
        n_half       = r_half;
        n_day        = r_day;
        n_acc        = r_acc;
        n_out_minute = r_out_minute;
        n_out_hour   = r_out_hour;
        n_out_half   = r_out_half;
        n_out_day    = r_out_day;
        n_out_total  = r_out_total;

        // Configuration must be written only while no transaction is in flight; the block itself does not enforce this.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESOLUTION: begin
                    n_res = i_cfg_data[RES_W-1:0];
                end
                CFG_COUNTER_MODE: begin
                    n_cmode = i_cfg_data[0];
                end
                default: begin
                    n_res = r_res;
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    // Minute level straight into its register; the sum starts from it.
                    n_minute = MIN_W'(i_impulse_count) * MIN_W'(r_res);
                    n_acc    = HALF_W'(MIN_W'(i_impulse_count) * MIN_W'(r_res));
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_state  = ST_MSUM;
                end
            end

            ST_MSUM: begin
                n_pend = sweep_issue;
                if (sweep_issue) begin
                    n_addr = r_addr + ADDR_W'(1);
                end
                if (r_pend) begin
                    n_acc = r_acc + HALF_W'(min_rdata);
                end
                if (sweep_done) begin
                    n_hour    = r_acc[HOUR_W-1:0];
                    n_mwrap   = min_wrap;
                    n_min_idx = min_wrap ? '0 : r_min_idx + MIN_IDX_W'(1);
                    n_addr    = '0;
                    n_pend    = 1'b0;
                    if (r_cmode) begin
                        n_total = r_total + TOTAL_W'(r_minute);
                        n_state = ST_FIN;
                    end else begin
                        // The accumulator already holds the hour level for the current slot.
                        n_state = ST_HSUM;
                    end
                end
            end

            ST_HSUM: begin
                n_pend = sweep_issue;
                if (sweep_issue) begin
                    n_addr = r_addr + ADDR_W'(1);
                end
                if (r_pend) begin
                    n_acc = r_acc + HALF_W'(hr_rdata);
                end
                if (sweep_done) begin
                    n_half = r_acc;
                    n_half_slot[r_hd_idx] = r_acc;
                    n_day = DAY_W'(r_acc) + DAY_W'(r_half_slot[!r_hd_idx]);
                    if (r_mwrap) begin
                        if (r_hr_idx >= HR_IDX_W'(HOURS_PER_HALF_DAY - 1)) begin
                            n_hr_idx = '0;
                            n_hd_idx = !r_hd_idx;
                        end else begin
                            n_hr_idx = r_hr_idx + HR_IDX_W'(1);
                        end
                    end
                    n_state = ST_FIN;
                end
            end

            ST_FIN: begin
                // Hold here until the result register is free.
                if (out_free) begin
                    n_out_minute = r_minute;
                    n_out_hour   = r_hour;
                    n_out_half   = r_cmode ? '0 : r_half;
                    n_out_day    = r_cmode ? '0 : r_day;
                    n_out_total  = r_cmode ? r_total : '0;
                    n_o_valid    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_res          <= '0;
            r_cmode        <= 1'b0;
            r_min_idx      <= '0;
            r_hr_idx       <= '0;
            r_hd_idx       <= 1'b0;
            r_half_slot[0] <= '0;
            r_half_slot[1] <= '0;
            r_total        <= '0;
            r_addr         <= '0;
            r_pend         <= 1'b0;
            r_mwrap        <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_cmode     <= n_cmode;
            r_min_idx   <= n_min_idx;
            r_hr_idx    <= n_hr_idx;
            r_hd_idx    <= n_hd_idx;
            r_half_slot <= n_half_slot;
            r_total     <= n_total;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_mwrap     <= n_mwrap;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_minute     <= n_minute;
        r_hour       <= n_hour;
        r_half       <= n_half;
        r_day        <= n_day;
        r_acc        <= n_acc;
        r_out_minute <= n_out_minute;
        r_out_hour   <= n_out_hour;
        r_out_half   <= n_out_half;
        r_out_day    <= n_out_day;
        r_out_total  <= n_out_total;
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_minute_level   = r_out_minute;
    assign o_hour_level     = r_out_hour;
    assign o_half_day_level = r_out_half;
    assign o_day_level      = r_out_day;
    assign o_running_total  = r_out_total;

endmodule

`default_nettype wire
